// ===== hw/rtl/lsti_pkg.sv =====
// Package for the stitched triangle fan indexer: payload structs, side codes,
// register indexes and field widths. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lsti_pkg;

    // Field widths
    localparam int unsigned GRID_W_BITS  = 13;
    localparam int unsigned PATCH_W_BITS = 9;
    localparam int unsigned COORD_BITS   = 9;
    localparam int unsigned LOD_BITS     = 3;
    localparam int unsigned INDEX_BITS   = 24;
    localparam int unsigned CFG_DATA_BITS = 13;
    localparam int unsigned CFG_IDX_BITS  = 1;

    // Register reset values
    localparam logic [GRID_W_BITS-1:0]  GRID_WIDTH_RESET = 13'd257;
    localparam logic [PATCH_W_BITS-1:0] PATCH_SIZE_RESET = 9'd33;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_GRID_WIDTH = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_PATCH_SIZE = 1'd1;

    // Fan walk order around the quad center
    typedef enum logic [1:0] {
        SIDE_LEFT   = 2'd0,
        SIDE_TOP    = 2'd1,
        SIDE_RIGHT  = 2'd2,
        SIDE_BOTTOM = 2'd3
    } t_side;

    // One quad description
    typedef struct packed {
        logic [COORD_BITS-1:0] quad_x;
        logic [COORD_BITS-1:0] quad_z;
        logic [LOD_BITS-1:0]   core_lod;
        logic                  left_coarser;
        logic                  right_coarser;
        logic                  top_coarser;
        logic                  bottom_coarser;
    } t_quad_in;

    // One triangle of the fan
    typedef struct packed {
        logic [INDEX_BITS-1:0] center_vertex;
        logic [INDEX_BITS-1:0] second_vertex;
        logic [INDEX_BITS-1:0] third_vertex;
        logic                  last_triangle;
    } t_tri_out;

endpackage

`default_nettype wire

// ===== hw/rtl/lod_stitched_triangle_fan_indexer_top.sv =====
// Stitched triangle fan indexer: turns one terrain quad into its 4 to 8 fan triangles.
// Depends on lsti_pkg.
`timescale 1ns / 1ps
`default_nettype none

// A quad beat is taken into a walker register, where the row multiply
// (quad_z times grid_width) and the center index are settled in the accept
// cycle. The walker then sends one triangle per cycle, while the output register is
// free or draining, into that register. A quad gives 8 triangles with all sides at
// the core level and one fewer for each coarser border side, down to 4 when all four
// sides are coarser (a patch that holds a single quad). The next quad is accepted in
// the cycle the last triangle of the current one moves to the output register, so
// quads follow with no gap. Indices are relative to the patch base and wrap modulo
// 2^24. Registers grid_width (index 0) and patch_size (index 1) are written through
// the plain write port; the user must write them only while idle (not enforced).
module lod_stitched_triangle_fan_indexer_top (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // Configuration write port
    input  wire                                  i_cfg_we,
    input  wire [lsti_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  wire [lsti_pkg::CFG_DATA_BITS-1:0]    i_cfg_wdata,
    // Quad input channel
    input  wire                                  i_in_valid,
    output logic                                 o_in_ready,
    input  lsti_pkg::t_quad_in                   i_in_data,
    // Triangle output channel
    output logic                                 o_out_valid,
    input  wire                                  i_out_ready,
    output lsti_pkg::t_tri_out                   o_out_data
);

    // Configuration registers
    logic [lsti_pkg::GRID_W_BITS-1:0]  r_grid_width;
    logic [lsti_pkg::PATCH_W_BITS-1:0] r_patch_size;

    // Walker state
    logic                               r_busy, n_busy;
    lsti_pkg::t_side                    r_side, n_side;
    logic                               r_half, n_half;
    logic [3:0]                         r_coarse, n_coarse;
    logic [lsti_pkg::LOD_BITS-1:0]      r_core, n_core;
    logic [lsti_pkg::INDEX_BITS-1:0]    r_cur, n_cur;
    logic [lsti_pkg::INDEX_BITS-1:0]    r_center, n_center;

    // Output register
    logic                               r_out_valid, n_out_valid;
    lsti_pkg::t_tri_out                 r_out, n_out;

    // Handshake and walk control
    logic                               w_emit;
    logic                               w_last;
    logic                               w_side_coarse;
    logic                               w_accept;

    // Load-time arithmetic
    logic [lsti_pkg::COORD_BITS-1:0]    w_step;
    logic [lsti_pkg::COORD_BITS-1:0]    w_fan;
    logic signed [10:0]                 w_endpos;
    logic [21:0]                        w_row;
    logic [lsti_pkg::INDEX_BITS-1:0]    w_base;
    logic [lsti_pkg::INDEX_BITS-1:0]    w_row_step;

    // Walk arithmetic
    logic [3:0]                         w_shift;
    logic [lsti_pkg::INDEX_BITS-1:0]    w_mag;
    logic [lsti_pkg::INDEX_BITS-1:0]    w_amt;
    logic [lsti_pkg::INDEX_BITS-1:0]    w_next;

    // A triangle leaves the walker when the output register is free or draining.
    always_comb begin
        w_side_coarse = r_coarse[r_side];
        w_emit        = r_busy && (!r_out_valid || i_out_ready);
        w_last        = (r_side == lsti_pkg::SIDE_BOTTOM) && (w_side_coarse || r_half);
        o_in_ready    = !r_busy || (w_emit && w_last);
        w_accept      = i_in_valid && o_in_ready;
    end

    // Quad setup: border tests, base and center indices.
    always_comb begin
        w_step     = lsti_pkg::COORD_BITS'(1) << i_in_data.core_lod;
        w_fan      = lsti_pkg::COORD_BITS'(2) << i_in_data.core_lod;
        w_endpos   = $signed({2'b00, r_patch_size}) - 11'sd1 - $signed({2'b00, w_fan});
        w_row      = 22'(i_in_data.quad_z * r_grid_width);
        w_base     = 24'(w_row) + 24'(i_in_data.quad_x);
        w_row_step = 24'({11'b0, r_grid_width} << i_in_data.core_lod);
    end

    // Current edge step: grid rows on left and right, columns on top and bottom.
    always_comb begin
        w_shift = {1'b0, r_core} + {3'b000, w_side_coarse};
        if ((r_side == lsti_pkg::SIDE_LEFT) || (r_side == lsti_pkg::SIDE_RIGHT)) begin
            w_mag = {11'b0, r_grid_width};
        end else begin
            w_mag = 24'd1;
        end
        w_amt = w_mag << w_shift;
        if ((r_side == lsti_pkg::SIDE_RIGHT) || (r_side == lsti_pkg::SIDE_BOTTOM)) begin
            w_next = r_cur - w_amt;
        end else begin
            w_next = r_cur + w_amt;
        end
    end

    // Next state of the walker and the output register.
    always_comb begin
        n_busy      = r_busy;
        n_side      = r_side;
        n_half      = r_half;
        n_coarse    = r_coarse;
        n_core      = r_core;
        n_cur       = r_cur;
        n_center    = r_center;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (w_emit) begin
            n_out_valid            = 1'b1;
            n_out.center_vertex    = r_center;
            n_out.second_vertex    = r_cur;
            n_out.third_vertex     = w_next;
            n_out.last_triangle    = w_last;
            n_cur                  = w_next;
            if (w_side_coarse || r_half) begin
                n_side = lsti_pkg::t_side'(r_side + 2'd1);
                n_half = 1'b0;
            end else begin
                n_half = 1'b1;
            end
            if (w_last) begin
                n_busy = 1'b0;
            end
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (w_accept) begin
            n_busy      = 1'b1;
            n_side      = lsti_pkg::SIDE_LEFT;
            n_half      = 1'b0;
            n_core      = i_in_data.core_lod;
            n_cur       = w_base;
            n_center    = w_base + w_row_step + 24'(w_step);
            // Coarse flags in walk order: left, top, right, bottom.
            n_coarse[0] = (i_in_data.quad_x == '0) && i_in_data.left_coarser;
            n_coarse[1] = ($signed({2'b00, i_in_data.quad_z}) == w_endpos)
                          && i_in_data.top_coarser;
            n_coarse[2] = ($signed({2'b00, i_in_data.quad_x}) == w_endpos)
                          && i_in_data.right_coarser;
            n_coarse[3] = (i_in_data.quad_z == '0) && i_in_data.bottom_coarser;
        end
    end

    // Control registers and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_side       <= lsti_pkg::SIDE_LEFT;
            r_half       <= 1'b0;
            r_grid_width <= lsti_pkg::GRID_WIDTH_RESET;
            r_patch_size <= lsti_pkg::PATCH_SIZE_RESET;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
            r_side      <= n_side;
            r_half      <= n_half;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    lsti_pkg::REG_GRID_WIDTH: r_grid_width <= i_cfg_wdata;
                    lsti_pkg::REG_PATCH_SIZE:
                        r_patch_size <= i_cfg_wdata[lsti_pkg::PATCH_W_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_coarse <= n_coarse;
        r_core   <= n_core;
        r_cur    <= n_cur;
        r_center <= n_center;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    // A new quad always starts its walk on the first half of the left side.
    a_start_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_busy && (r_side == lsti_pkg::SIDE_LEFT) && !r_half))
        else $error("fan walk did not restart on the left side");

    // The walker holds its position while the output register is stalled.
    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_out_valid && !i_out_ready) |=> ($stable(r_cur) && $stable(r_side)))
        else $error("walker moved during an output stall");

    // The fan center stays fixed until the next quad is loaded.
    a_center_fixed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !w_accept) |=> $stable(r_center))
        else $error("fan center changed inside a quad");

    // A triangle that is not the last one keeps the walker busy.
    a_not_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && !w_last) |=> r_busy)
        else $error("walker went idle before the last triangle");

    // A beat that ends a quad carries the last flag on the output.
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_last) |=> (o_out_valid && o_out_data.last_triangle))
        else $error("last triangle flag missing");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_lod_stitched_triangle_fan_indexer_top.sv =====
// Testbench for lod_stitched_triangle_fan_indexer_top: sends quad beats, predicts every
// fan triangle into a scoreboard queue and checks each triangle beat field by field.
// Depends on lsti_pkg and the top-level RTL only.
`timescale 1ns / 1ps

module tb_lod_stitched_triangle_fan_indexer_top;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 16;
    localparam int LONG_HOLD     = 240;
    localparam int TOP_LOD       = 7;

    logic                               i_clk       = 1'b0;
    logic                               i_rst_n     = 1'b0;
    logic                               i_cfg_we    = 1'b0;
    logic [lsti_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx   = lsti_pkg::REG_GRID_WIDTH;
    logic [lsti_pkg::CFG_DATA_BITS-1:0] i_cfg_wdata = '0;
    logic                               i_in_valid  = 1'b0;
    logic                               o_in_ready;
    lsti_pkg::t_quad_in                 i_in_data   = '0;
    logic                               o_out_valid;
    logic                               i_out_ready = 1'b0;
    lsti_pkg::t_tri_out                 o_out_data;

    // Shadow copy of the registers as the block should hold them.
    logic [lsti_pkg::GRID_W_BITS-1:0]  grid_width_shadow = lsti_pkg::GRID_WIDTH_RESET;
    logic [lsti_pkg::PATCH_W_BITS-1:0] patch_size_shadow = lsti_pkg::PATCH_SIZE_RESET;

    lsti_pkg::t_tri_out tri_expect[$];
    lsti_pkg::t_tri_out tri_want;
    int       fail_count    = 0;
    int       cycle_count   = 0;
    bit       steady        = 1'b0;
    bit       hold_request  = 1'b0;

    lod_stitched_triangle_fan_indexer_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Run limit, far above the slowest legal run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Idle length: mostly short, now and then long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(1, 2);
        if (r < 95) return $urandom_range(3, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic int sender_gap();
        if (steady || $urandom_range(0, 1) == 0) return 0;
        return idle_len();
    endfunction

    // Expected fan of one quad: left (+z), top (+x), right (-z), bottom (-x).
    task automatic predict_fan(input lsti_pkg::t_quad_in q);
        logic [lsti_pkg::INDEX_BITS-1:0] step, fan_step, gw, mag, amt, center, cur, nxt;
        int                 last_pos;
        int                 count;
        bit                 coarse [4];
        lsti_pkg::t_tri_out tri_beat;
        step     = 24'd1 << q.core_lod;
        fan_step = step << 1;
        gw       = 24'(grid_width_shadow);
        last_pos = int'(patch_size_shadow) - 1 - int'(fan_step);
        coarse[lsti_pkg::SIDE_LEFT]   = (q.quad_x == 0) && q.left_coarser;
        coarse[lsti_pkg::SIDE_TOP]    = (int'(q.quad_z) == last_pos) && q.top_coarser;
        coarse[lsti_pkg::SIDE_RIGHT]  = (int'(q.quad_x) == last_pos) && q.right_coarser;
        coarse[lsti_pkg::SIDE_BOTTOM] = (q.quad_z == 0) && q.bottom_coarser;
        center = (24'(q.quad_z) + step) * gw + 24'(q.quad_x) + step;
        cur    = 24'(q.quad_z) * gw + 24'(q.quad_x);
        for (int k = 0; k < 4; k++) begin
            mag   = (k == lsti_pkg::SIDE_LEFT || k == lsti_pkg::SIDE_RIGHT) ? gw : 24'd1;
            count = coarse[k] ? 1 : 2;
            amt   = (coarse[k] ? fan_step : step) * mag;
            for (int i = 0; i < count; i++) begin
                nxt = (k >= lsti_pkg::SIDE_RIGHT) ? cur - amt : cur + amt;
                tri_beat.center_vertex = center;
                tri_beat.second_vertex = cur;
                tri_beat.third_vertex  = nxt;
                tri_beat.last_triangle = 1'b0;
                tri_expect.push_back(tri_beat);
                cur = nxt;
            end
        end
        tri_expect[tri_expect.size() - 1].last_triangle = 1'b1;
    endtask

    // Offer one quad beat, hold it until accepted, then maybe idle.
    task automatic send_quad(input lsti_pkg::t_quad_in q);
        int gap;
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in_data  = q;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_fan(q);
        gap = sender_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Stop sending and wait until every predicted triangle has come out.
    task automatic wait_fans_done();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (tri_expect.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [lsti_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [lsti_pkg::CFG_DATA_BITS-1:0] value);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_idx   = idx;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == lsti_pkg::REG_GRID_WIDTH) grid_width_shadow = value;
        else patch_size_shadow = value[lsti_pkg::PATCH_W_BITS-1:0];
    endtask

    task automatic set_grid(input logic [lsti_pkg::CFG_DATA_BITS-1:0] gw,
                            input logic [lsti_pkg::CFG_DATA_BITS-1:0] ps);
        wait_fans_done();
        write_reg(lsti_pkg::REG_GRID_WIDTH, gw);
        write_reg(lsti_pkg::REG_PATCH_SIZE, ps);
    endtask

    function automatic lsti_pkg::t_quad_in make_quad(input int x, input int z, input int lod,
                                                     input logic [3:0] flags);
        lsti_pkg::t_quad_in q;
        q.quad_x         = lsti_pkg::COORD_BITS'(x);
        q.quad_z         = lsti_pkg::COORD_BITS'(z);
        q.core_lod       = lsti_pkg::LOD_BITS'(lod);
        q.left_coarser   = flags[3];
        q.right_coarser  = flags[2];
        q.top_coarser    = flags[1];
        q.bottom_coarser = flags[0];
        return q;
    endfunction

    // Position biased toward the two borders, else on the fan grid.
    function automatic int pick_pos(input int fan_step, input int last_pos);
        int r;
        r = $urandom_range(0, 2);
        if (r == 0) return 0;
        if (r == 1) return last_pos;
        return fan_step * $urandom_range(0, last_pos / fan_step);
    endfunction

    // A quad that fits the current patch, at a level the patch can hold.
    function automatic lsti_pkg::t_quad_in wellformed_quad();
        int top_lod;
        int lod;
        int fan_step;
        int last_pos;
        top_lod = 0;
        while (top_lod < TOP_LOD && (4 << top_lod) <= int'(patch_size_shadow) - 1)
            top_lod++;
        lod      = $urandom_range(0, top_lod);
        fan_step = 2 << lod;
        last_pos = int'(patch_size_shadow) - 1 - fan_step;
        return make_quad(pick_pos(fan_step, last_pos), pick_pos(fan_step, last_pos), lod,
                         4'($urandom));
    endfunction

    function automatic lsti_pkg::t_quad_in noise_quad();
        logic [31:0] r;
        r = $urandom;
        return r[$bits(lsti_pkg::t_quad_in)-1:0];
    endfunction

    // Receiver: random stalls, long hold-off on request.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_ready  = 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
            end else if (steady || $urandom_range(0, 3) != 0) begin
                i_out_ready = 1'b1;
            end else begin
                i_out_ready = 1'b0;
                repeat (idle_len() - 1) @(negedge i_clk);
            end
        end
    end

    task automatic check_field(input string name,
                               input logic [lsti_pkg::INDEX_BITS-1:0] want,
                               input logic [lsti_pkg::INDEX_BITS-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Scoreboard: each triangle beat against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (tri_expect.size() == 0) begin
                $error("triangle beat with nothing outstanding: %h", o_out_data);
                fail_count++;
            end else begin
                tri_want = tri_expect.pop_front();
                check_field("center_vertex", tri_want.center_vertex, o_out_data.center_vertex);
                check_field("second_vertex", tri_want.second_vertex, o_out_data.second_vertex);
                check_field("third_vertex", tri_want.third_vertex, o_out_data.third_vertex);
                check_field("last_triangle", 24'(tri_want.last_triangle),
                            24'(o_out_data.last_triangle));
            end
        end
    end

    // Reset values of the registers: 257 wide grid, 33 vertex patch.
    task automatic test_reset_defaults();
        send_quad(make_quad(0, 0, 3, 4'b1111));
        send_quad(make_quad(16, 16, 3, 4'b1111));
        send_quad(make_quad(0, 0, 4, 4'b1111));
    endtask

    // One-quad patch: every side is on the border, so all flag mixes matter.
    task automatic test_border_flags();
        set_grid(13'd3, 13'd3);
        for (int f = 0; f < 16; f++) send_quad(make_quad(0, 0, 0, 4'(f)));
        // Patch too small for the level: right and top never count as border.
        send_quad(make_quad(0, 0, 7, 4'b1111));
    endtask

    // Register values past the usable range, and a quad off the fan grid.
    task automatic test_register_extremes();
        set_grid(13'd8191, 13'd511);
        send_quad(make_quad(254, 254, 7, 4'b1111));
        send_quad(make_quad(511, 511, 7, 4'b1111));
        send_quad(make_quad(5, 7, 1, 4'b1111));
        set_grid(13'd0, 13'd0);
        send_quad(make_quad(0, 0, 0, 4'b1111));
    endtask

    // Receiver holds off while quads keep coming, then the sender drains.
    task automatic test_backpressure();
        set_grid(13'd257, 13'd33);
        steady       = 1'b1;
        hold_request = 1'b1;
        for (int n = 0; n < 24; n++) send_quad(wellformed_quad());
        wait_fans_done();
        steady = 1'b0;
    endtask

    // Well-formed quads over a range of grids, extremes first.
    task automatic test_wellformed_random();
        int gw;
        int ps;
        for (int phase = 0; phase < 9; phase++) begin
            case (phase)
                0: begin
                    gw = 3;
                    ps = 3;
                end
                1: begin
                    gw = 4097;
                    ps = 257;
                end
                2: begin
                    gw = 257;
                    ps = 257;
                end
                default: begin
                    gw = $urandom_range(3, 4097);
                    ps = ($urandom_range(0, 1) != 0) ? (1 << $urandom_range(1, 8)) + 1
                                                     : 2 * $urandom_range(1, 128) + 1;
                end
            endcase
            set_grid(13'(gw), 13'(ps));
            steady = (phase == 4);
            for (int n = 0; n < 40; n++) send_quad(wellformed_quad());
        end
        steady = 1'b0;
    endtask

    // Any field values, with register values anywhere in their width.
    task automatic test_noise_random();
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: set_grid(13'd8191, 13'($urandom));
                1: set_grid(13'd0, 13'd2);
                default: set_grid(13'($urandom), 13'($urandom));
            endcase
            for (int n = 0; n < 20; n++) send_quad(noise_quad());
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_reset_defaults();
        test_border_flags();
        test_register_extremes();
        test_backpressure();
        test_wellformed_random();
        test_noise_random();
        wait_fans_done();
        if (fail_count == 0 && tri_expect.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/lsti_pkg.sv
hw/rtl/lod_stitched_triangle_fan_indexer_top.sv
sim/tb_lod_stitched_triangle_fan_indexer_top.sv
